// ===== src/dda_line_rasterizer_unit_defines.svh =====
// Assertion macros for the DDA line rasterizer.
// Used by the top level only; expects clk and arst_n in scope.
`ifndef DDA_LINE_RASTERIZER_UNIT_DEFINES_SVH
`define DDA_LINE_RASTERIZER_UNIT_DEFINES_SVH

// same-cycle implication
`define DLR_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define DLR_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== src/dlr_pkg.sv =====
// Shared types and defaults for the DDA line rasterizer.
// No dependencies.
package dlr_pkg;

	localparam int COORD_BITS_DEF = 10;
	localparam int FRAC_BITS_DEF  = 16;
	localparam int MAX_SPAN_DEF   = 64;

	typedef enum logic [5:0] {
		ST_IDLE  = 6'b000001,
		ST_SETUP = 6'b000010,
		ST_CHECK = 6'b000100,
		ST_DIV   = 6'b001000,
		ST_FIX   = 6'b010000,
		ST_EMIT  = 6'b100000
	} dlr_state_t;

	// controller -> datapath
	typedef struct packed {
		logic load_in;   // capture segment endpoints
		logic setup;     // deltas, axis choice, endpoint swap
		logic div_start; // load divider, accumulator and point counter
		logic div_step;  // one quotient bit
		logic fix;       // apply sign to quotient
		logic emit_adv;  // point beat taken, step to next point
	} dlr_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic zero_len;
		logic div_done;
		logic last_pt;
	} dlr_stat_t;

endpackage

// ===== src/dlr_ctrl.sv =====
// Sequencer for the DDA line rasterizer.
// Depends on dlr_pkg.
module dlr_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           s_tvalid,
	output logic           s_tready,
	output logic           m_tvalid,
	input  logic           m_tready,
	input  dlr_pkg::dlr_stat_t stat,
	output dlr_pkg::dlr_cmd_t  cmd
);

	dlr_pkg::dlr_state_t state_q, state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= dlr_pkg::ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	assign s_tready = (state_q == dlr_pkg::ST_IDLE);
	assign m_tvalid = (state_q == dlr_pkg::ST_EMIT);

	always_comb begin
		state_nxt = state_q;
		cmd       = '0;
		case (state_q)
			dlr_pkg::ST_IDLE: begin
				if (s_tvalid) begin
					cmd.load_in = 1'b1;
					state_nxt   = dlr_pkg::ST_SETUP;
				end
			end
			dlr_pkg::ST_SETUP: begin
				cmd.setup = 1'b1;
				state_nxt = dlr_pkg::ST_CHECK;
			end
			dlr_pkg::ST_CHECK: begin
				// zero-length segment: no points
				if (stat.zero_len) begin
					state_nxt = dlr_pkg::ST_IDLE;
				end else begin
					cmd.div_start = 1'b1;
					state_nxt     = dlr_pkg::ST_DIV;
				end
			end
			dlr_pkg::ST_DIV: begin
				cmd.div_step = 1'b1;
				if (stat.div_done) begin
					state_nxt = dlr_pkg::ST_FIX;
				end
			end
			dlr_pkg::ST_FIX: begin
				cmd.fix   = 1'b1;
				state_nxt = dlr_pkg::ST_EMIT;
			end
			dlr_pkg::ST_EMIT: begin
				if (m_tready) begin
					cmd.emit_adv = 1'b1;
					if (stat.last_pt) begin
						state_nxt = dlr_pkg::ST_IDLE;
					end
				end
			end
			default: begin
				state_nxt = dlr_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

// ===== src/dlr_datapath.sv =====
// Datapath of the DDA line rasterizer: setup, restoring divider, DDA stepper.
// Depends on dlr_pkg.
module dlr_datapath #(
	parameter int COORD_BITS = dlr_pkg::COORD_BITS_DEF,
	parameter int FRAC_BITS  = dlr_pkg::FRAC_BITS_DEF,
	parameter int MAX_SPAN   = dlr_pkg::MAX_SPAN_DEF
) (
	input  logic                  clk,
	input  dlr_pkg::dlr_cmd_t     cmd,
	output dlr_pkg::dlr_stat_t    stat,
	input  logic [COORD_BITS-1:0] start_x,
	input  logic [COORD_BITS-1:0] start_y,
	input  logic [COORD_BITS-1:0] end_x,
	input  logic [COORD_BITS-1:0] end_y,
	output logic [COORD_BITS-1:0] pixel_x,
	output logic [COORD_BITS-1:0] pixel_y,
	output logic                  truncated
);

	localparam int DVW = COORD_BITS + FRAC_BITS;
	localparam int DCW = $clog2(DVW + 1);
	localparam int SPW = $clog2(MAX_SPAN + 1);
	localparam int AW  = COORD_BITS + FRAC_BITS + 2;

	logic [COORD_BITS-1:0] sx_q, sy_q, ex_q, ey_q;
	logic [COORD_BITS-1:0] dmaj_q, admin_q, maj0_q, min0_q, majc_q;
	logic                  xmaj_q, mneg_q, trunc_q;
	logic [COORD_BITS:0]   rem_q;
	logic [DVW-1:0]        dvd_q;
	logic [DCW-1:0]        dcnt_q;
	logic [SPW-1:0]        left_q;
	logic signed [AW-1:0]  slope_q, acc_q;

	logic signed [COORD_BITS:0] dx, dy, ndx, ndy;
	logic [COORD_BITS-1:0]      adx, ady;
	logic                       xmaj;
	logic [COORD_BITS:0]        rem_sh, rem_sub;
	logic                       ge;
	logic signed [AW-1:0]       q_ext;
	logic                       over;
	logic [COORD_BITS-1:0]      minc;

	// setup: deltas and magnitudes
	always_comb begin
		dx   = $signed({1'b0, ex_q}) - $signed({1'b0, sx_q});
		dy   = $signed({1'b0, ey_q}) - $signed({1'b0, sy_q});
		ndx  = -dx;
		ndy  = -dy;
		adx  = dx[COORD_BITS] ? ndx[COORD_BITS-1:0] : dx[COORD_BITS-1:0];
		ady  = dy[COORD_BITS] ? ndy[COORD_BITS-1:0] : dy[COORD_BITS-1:0];
		xmaj = adx > ady;
	end

	// one restoring-division step
	always_comb begin
		rem_sh  = {rem_q[COORD_BITS-1:0], dvd_q[DVW-1]};
		ge      = rem_sh >= {1'b0, dmaj_q};
		rem_sub = rem_sh - {1'b0, dmaj_q};
		// quotient never exceeds 1.0, so FRAC_BITS+1 bits hold it
		q_ext   = AW'(dvd_q[FRAC_BITS:0]);
		over    = dmaj_q > COORD_BITS'(MAX_SPAN);
	end

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			sx_q <= start_x;
			sy_q <= start_y;
			ex_q <= end_x;
			ey_q <= end_y;
		end
		if (cmd.setup) begin
			xmaj_q <= xmaj;
			// the minor delta's sign flips along with a swap, so its sign is dx^dy
			mneg_q <= dx[COORD_BITS] ^ dy[COORD_BITS];
			if (xmaj) begin
				dmaj_q  <= adx;
				admin_q <= ady;
				maj0_q  <= dx[COORD_BITS] ? ex_q : sx_q;
				min0_q  <= dx[COORD_BITS] ? ey_q : sy_q;
			end else begin
				dmaj_q  <= ady;
				admin_q <= adx;
				maj0_q  <= dy[COORD_BITS] ? ey_q : sy_q;
				min0_q  <= dy[COORD_BITS] ? ex_q : sx_q;
			end
		end
		if (cmd.div_start) begin
			rem_q   <= '0;
			dvd_q   <= {admin_q, {FRAC_BITS{1'b0}}};
			dcnt_q  <= DCW'(DVW);
			acc_q   <= AW'({min0_q, {FRAC_BITS{1'b0}}});
			majc_q  <= maj0_q;
			trunc_q <= over;
			left_q  <= over ? SPW'(MAX_SPAN) : dmaj_q[SPW-1:0];
		end
		if (cmd.div_step) begin
			rem_q  <= ge ? rem_sub : rem_sh;
			dvd_q  <= {dvd_q[DVW-2:0], ge};
			dcnt_q <= dcnt_q - DCW'(1);
		end
		if (cmd.fix) begin
			slope_q <= mneg_q ? -q_ext : q_ext;
		end
		if (cmd.emit_adv) begin
			acc_q  <= acc_q + slope_q;
			majc_q <= majc_q + COORD_BITS'(1);
			left_q <= left_q - SPW'(1);
		end
	end

	// floor(acc >> FRAC_BITS) masked to the coordinate width
	assign minc = acc_q[FRAC_BITS +: COORD_BITS];

	assign pixel_x   = xmaj_q ? majc_q : minc;
	assign pixel_y   = xmaj_q ? minc : majc_q;
	assign truncated = trunc_q;

	assign stat.zero_len = (dmaj_q == '0);
	assign stat.div_done = (dcnt_q == DCW'(1));
	assign stat.last_pt  = (left_q == SPW'(1));

endmodule

// ===== src/dda_line_rasterizer_unit.sv =====
// Channel  | Signals                          | Beat
// ---------+----------------------------------+-------------------------------------
// segment  | s_tvalid s_tready s_tdata        | start_x, start_y, end_x, end_y
// point    | m_tvalid m_tready m_tdata m_tlast m_tuser | pixel_x, pixel_y; tlast=last; tuser=truncated
//
// A segment passes setup and a restoring divider for the slope before its first point,
// then one point per cycle while m_tready is high; up to MAX_SPAN points. Zero-length
// segments return to idle with no points.
// One segment at a time: s_tready is high only when idle.
// Async active-low reset returns the sequencer to idle.
// Top level of the DDA line rasterizer; depends on dlr_pkg, dlr_ctrl, dlr_datapath.
`include "dda_line_rasterizer_unit_defines.svh"

module dda_line_rasterizer_unit #(
	parameter int COORD_BITS = dlr_pkg::COORD_BITS_DEF,
	parameter int FRAC_BITS  = dlr_pkg::FRAC_BITS_DEF,
	parameter int MAX_SPAN   = dlr_pkg::MAX_SPAN_DEF,
	localparam int IN_W      = ((4 * COORD_BITS + 7) / 8) * 8,
	localparam int OUT_W     = ((2 * COORD_BITS + 7) / 8) * 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	input  logic [IN_W-1:0]  s_tdata,  // start_x, start_y, end_x, end_y
	output logic             m_tvalid,
	input  logic             m_tready,
	output logic [OUT_W-1:0] m_tdata,  // pixel_x, pixel_y
	output logic             m_tlast,
	output logic             m_tuser   // truncated
);

	dlr_pkg::dlr_cmd_t  cmd;
	dlr_pkg::dlr_stat_t stat;
	logic [COORD_BITS-1:0] pixel_x, pixel_y;

	dlr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	dlr_datapath #(
		.COORD_BITS (COORD_BITS),
		.FRAC_BITS  (FRAC_BITS),
		.MAX_SPAN   (MAX_SPAN)
	) u_datapath (
		.clk       (clk),
		.cmd       (cmd),
		.stat      (stat),
		.start_x   (s_tdata[0*COORD_BITS +: COORD_BITS]),
		.start_y   (s_tdata[1*COORD_BITS +: COORD_BITS]),
		.end_x     (s_tdata[2*COORD_BITS +: COORD_BITS]),
		.end_y     (s_tdata[3*COORD_BITS +: COORD_BITS]),
		.pixel_x   (pixel_x),
		.pixel_y   (pixel_y),
		.truncated (m_tuser)
	);

	assign m_tdata = OUT_W'({pixel_y, pixel_x});
	assign m_tlast = stat.last_pt;

	`DLR_ASSERT_NOW(a_one_side, m_tvalid, !s_tready, "segment accepted while points pending")
	`DLR_ASSERT_NEXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready && !m_tvalid,
		"sequencer did not enter setup after segment beat")
	`DLR_ASSERT_NEXT(a_done_after_last, m_tvalid && m_tready && m_tlast, !m_tvalid && s_tready,
		"points continue after last beat")

endmodule

// ===== dv/dda_line_rasterizer_unit_chk.sv =====
`timescale 1ns / 100ps
// Point scoreboard for the DDA line rasterizer: watches both channels,
// plots every accepted segment beat and compares the point beats in order.
// Depends on dlr_pkg for the default sizes.
module dda_line_rasterizer_unit_chk #(
	parameter int CB    = dlr_pkg::COORD_BITS_DEF,
	parameter int FB    = dlr_pkg::FRAC_BITS_DEF,
	parameter int MS    = dlr_pkg::MAX_SPAN_DEF,
	parameter int IN_W  = ((4 * CB + 7) / 8) * 8,
	parameter int OUT_W = ((2 * CB + 7) / 8) * 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	input  logic             s_tready,
	input  logic [IN_W-1:0]  s_tdata,  // start_x, start_y, end_x, end_y
	input  logic             m_tvalid,
	input  logic             m_tready,
	input  logic [OUT_W-1:0] m_tdata,  // pixel_x, pixel_y
	input  logic             m_tlast,
	input  logic             m_tuser,  // truncated
	output int               mismatch_count,
	output int               points_pending
);

	typedef struct packed {
		logic [CB-1:0] px;
		logic [CB-1:0] py;
		logic          last;
		logic          clipped;
	} point_t;

	point_t expected_points[$];
	int     n_err   = 0;
	int     n_left  = 0;
	int     beat_no = 0;

	assign mismatch_count = n_err;
	assign points_pending = n_left;

	task automatic report_mismatch(input string msg);
		$display("MISMATCH point beat %0d: %s", beat_no, msg);
		n_err++;
	endtask

	// DDA walk along the major axis with a signed 48.16 accumulator (FB fraction bits) on the minor axis
	task automatic plot_segment(input logic [CB-1:0] x0, input logic [CB-1:0] y0,
			input logic [CB-1:0] x1, input logic [CB-1:0] y1);
		longint dx, dy, adx, ady, maj0, min0, dmaj, dmin, slope, acc, span, majc, minc;
		bit     xmaj;
		point_t pt;
		dx   = longint'(x1) - longint'(x0);
		dy   = longint'(y1) - longint'(y0);
		adx  = (dx < 0) ? -dx : dx;
		ady  = (dy < 0) ? -dy : dy;
		xmaj = adx > ady;  // a tie goes to Y
		if (xmaj) begin
			maj0 = longint'(x0); min0 = longint'(y0); dmaj = dx; dmin = dy;
			if (dmaj < 0) begin
				maj0 = longint'(x1); min0 = longint'(y1); dmaj = -dmaj; dmin = -dmin;
			end
		end else begin
			maj0 = longint'(y0); min0 = longint'(x0); dmaj = dy; dmin = dx;
			if (dmaj < 0) begin
				maj0 = longint'(y1); min0 = longint'(x1); dmaj = -dmaj; dmin = -dmin;
			end
		end
		if (dmaj == 0)
			return;
		// signed division truncates toward zero
		slope = (dmin * (longint'(1) << FB)) / dmaj;
		acc   = min0 << FB;
		span  = (dmaj > MS) ? longint'(MS) : dmaj;
		for (longint k = 0; k < span; k++) begin
			majc       = maj0 + k;
			minc       = acc >>> FB;
			pt.px      = xmaj ? majc[CB-1:0] : minc[CB-1:0];
			pt.py      = xmaj ? minc[CB-1:0] : majc[CB-1:0];
			pt.last    = (k == span - 1);
			pt.clipped = (dmaj > MS);
			expected_points.push_back(pt);
			acc += slope;
		end
	endtask

	always @(posedge clk) begin
		point_t want;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				if (expected_points.size() == 0) begin
					report_mismatch($sformatf("unexpected beat x=%0d y=%0d",
						m_tdata[CB-1:0], m_tdata[2*CB-1:CB]));
				end else begin
					want = expected_points.pop_front();
					if (m_tdata[CB-1:0] !== want.px)
						report_mismatch($sformatf("pixel_x %0d, want %0d",
							m_tdata[CB-1:0], want.px));
					if (m_tdata[2*CB-1:CB] !== want.py)
						report_mismatch($sformatf("pixel_y %0d, want %0d",
							m_tdata[2*CB-1:CB], want.py));
					if (m_tlast !== want.last)
						report_mismatch($sformatf("tlast %b, want %b", m_tlast, want.last));
					if (m_tuser !== want.clipped)
						report_mismatch($sformatf("truncated %b, want %b",
							m_tuser, want.clipped));
				end
				beat_no++;
			end
			if (s_tvalid && s_tready)
				plot_segment(s_tdata[CB-1:0], s_tdata[2*CB-1:CB],
					s_tdata[3*CB-1:2*CB], s_tdata[4*CB-1:3*CB]);
		end
		n_left = expected_points.size();
	end

endmodule

// ===== dv/dda_line_rasterizer_unit_tb.sv =====
`timescale 1ns / 100ps
// Regression bench for dda_line_rasterizer_unit: directed and random segments
// with random source gaps and sink stalls; depends on dlr_pkg and the checker.
module dda_line_rasterizer_unit_tb;

	localparam int CB    = dlr_pkg::COORD_BITS_DEF;
	localparam int IN_W  = ((4 * CB + 7) / 8) * 8;
	localparam int OUT_W = ((2 * CB + 7) / 8) * 8;
	localparam int CMAX  = (1 << CB) - 1;

	logic             clk      = 1'b0;
	logic             arst_n   = 1'b0;
	logic             s_tvalid = 1'b0;
	logic             s_tready;
	logic [IN_W-1:0]  s_tdata  = '0;
	logic             m_tvalid;
	logic             m_tready = 1'b0;
	logic [OUT_W-1:0] m_tdata;
	logic             m_tlast;
	logic             m_tuser;
	int               mismatch_count;
	int               points_pending;
	int               seg_no   = 0;

	dda_line_rasterizer_unit u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser)
	);

	dda_line_rasterizer_unit_chk u_chk (
		.clk            (clk),
		.arst_n         (arst_n),
		.s_tvalid       (s_tvalid),
		.s_tready       (s_tready),
		.s_tdata        (s_tdata),
		.m_tvalid       (m_tvalid),
		.m_tready       (m_tready),
		.m_tdata        (m_tdata),
		.m_tlast        (m_tlast),
		.m_tuser        (m_tuser),
		.mismatch_count (mismatch_count),
		.points_pending (points_pending)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// offset a coordinate, folding back when it would leave the range
	function automatic int near(input int base, input int off);
		if (base + off > CMAX || base + off < 0)
			return base - off;
		return base + off;
	endfunction

	task automatic send_segment(input int x0, input int y0, input int x1, input int y1);
		int              gap;
		logic [IN_W-1:0] beat;
		// every fourth run of 40 segments goes back to back
		gap = (((seg_no / 40) % 4) == 3) ? 0 : $urandom_range(0, 9);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		beat = '0;
		beat[4*CB-1:0] = {y1[CB-1:0], x1[CB-1:0], y0[CB-1:0], x0[CB-1:0]};
		s_tvalid <= 1'b1;
		s_tdata  <= beat;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		seg_no++;
	endtask

	// point sink: random stall before every beat, with calm stretches
	initial begin
		int n;
		int beats;
		beats = 0;
		@(posedge arst_n);
		forever begin
			n = (((beats / 100) % 3) == 2) ? 0 : $urandom_range(0, 9);
			if (n > 0) begin
				m_tready <= 1'b0;
				repeat (n) @(posedge clk);
			end
			m_tready <= 1'b1;
			@(posedge clk);
			while (!m_tvalid) @(posedge clk);
			beats++;
		end
	end

	initial begin
		int kind, x0, y0, x1, y1, d;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// zero length, axis aligned both ways, ties, span limit edges, corners
		send_segment(0, 0, 0, 0);
		send_segment(CMAX, CMAX, CMAX, CMAX);
		send_segment(0, 0, 10, 0);
		send_segment(10, 5, 0, 5);
		send_segment(7, 0, 7, 12);
		send_segment(7, 12, 7, 0);
		send_segment(0, 0, 20, 20);
		send_segment(20, 20, 0, 0);
		send_segment(0, 0, 64, 3);
		send_segment(0, 0, 65, 3);
		send_segment(0, 0, CMAX, CMAX);
		send_segment(CMAX, 0, 0, CMAX);
		send_segment(CMAX, 0, 0, 0);
		send_segment(0, CMAX, 0, 0);
		send_segment(5, 5, 6, 5);
		send_segment(5, 5, 5, 4);
		send_segment(100, 100, 150, 90);
		send_segment(100, 100, 90, 150);
		send_segment(100, 100, 37, 137);
		send_segment(0, 0, 3, 1);
		send_segment(1000, CMAX, CMAX, 1000);
		send_segment(3, 0, 0, 64);
		send_segment(0, 0, 63, 64);
		send_segment(512, 511, 575, 512);

		repeat (406) begin
			kind = $urandom_range(0, 99);
			x0 = $urandom_range(0, CMAX);
			y0 = $urandom_range(0, CMAX);
			if (kind < 55) begin
				x1 = near(x0, $urandom_range(0, 140) - 70);
				y1 = near(y0, $urandom_range(0, 140) - 70);
			end else if (kind < 70) begin
				x1 = $urandom_range(0, CMAX);
				y1 = $urandom_range(0, CMAX);
			end else if (kind < 78) begin
				x1 = x0;
				y1 = y0;
			end else if (kind < 90) begin
				// diagonal ties and axis-aligned runs
				d  = $urandom_range(0, 140) - 70;
				x1 = near(x0, d);
				case ($urandom_range(0, 2))
					0: y1 = near(y0, ($urandom_range(0, 1) != 0) ? d : -d);
					1: y1 = y0;
					default: begin
						x1 = x0;
						y1 = near(y0, d);
					end
				endcase
			end else begin
				x1 = near(x0, $urandom_range(0, 6) - 3);
				y1 = near(y0, $urandom_range(0, 6) - 3);
			end
			send_segment(x0, y0, x1, y1);
		end
		s_tvalid <= 1'b0;

		@(posedge clk);
		while (points_pending != 0) @(posedge clk);
		repeat (40) @(posedge clk);
		if (mismatch_count == 0 && points_pending == 0) begin
			$display("dda_line_rasterizer_unit regression: pass");
		end else begin
			$display("dda_line_rasterizer_unit regression: fail");
		end
		$finish;
	end

	initial begin
		#20_000_000;
		$display("TIMEOUT with %0d points outstanding", points_pending);
		$display("dda_line_rasterizer_unit regression: fail");
		$finish;
	end

endmodule

// ===== files.f =====
+incdir+src
src/dlr_pkg.sv
src/dlr_ctrl.sv
src/dlr_datapath.sv
src/dda_line_rasterizer_unit.sv
dv/dda_line_rasterizer_unit_chk.sv
dv/dda_line_rasterizer_unit_tb.sv
